[rtl/ksc_pkg.sv]
// Keyword score confirmation package: item and result structs, register map,
// class codes and the score clamp used by the lanes.
`timescale 1ns / 1ps

package ksc_pkg;

   localparam int unsigned CLASS_COUNT = 5;
   localparam int unsigned SCORE_W     = 10;
   localparam int unsigned CLASS_W     = 3;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 10;

   typedef logic [SCORE_W-1:0] score_type;
   typedef logic [CLASS_W-1:0] class_type;

   localparam score_type SCORE_MAX = 10'd1000;
   localparam logic [7:0] RUN_MAX  = 8'd255;

   localparam class_type CLS_NOISE   = 3'd0;
   localparam class_type CLS_OFF     = 3'd1;
   localparam class_type CLS_ON      = 3'd2;
   localparam class_type CLS_TIME    = 3'd3;
   localparam class_type CLS_WEATHER = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_ON_OFF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_OTHER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_ON_OFF    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_OTHER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN_WINDOWS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANTI_FLIP_WINDOWS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_MARGIN        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP_WINDOWS    = 3'd7;

   typedef struct packed {
      logic [9:0] threshold_on_off;
      logic [9:0] threshold_other;
      logic [7:0] confirm_on_off;
      logic [7:0] confirm_other;
      logic [7:0] cooldown_windows;
      logic [7:0] anti_flip_windows;
      logic [9:0] min_margin;
      logic [7:0] warmup_windows;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      threshold_on_off:  10'd700,
      threshold_other:   10'd550,
      confirm_on_off:    8'd3,
      confirm_other:     8'd2,
      cooldown_windows:  8'd4,
      anti_flip_windows: 8'd8,
      min_margin:        10'd150,
      warmup_windows:    8'd4
   };

   typedef struct packed {
      score_type score_noise;
      score_type score_off;
      score_type score_on;
      score_type score_time;
      score_type score_weather;
   } req_type;

   typedef struct packed {
      class_type          top_class;
      score_type          top_confidence;
      logic [COUNT_W-1:0] window_number;
      logic [COUNT_W-1:0] prior_event_number;
      logic               confirmed;
      logic [COUNT_W-1:0] event_number;
   } rsp_type;

   // ranked window after the margin check
   typedef struct packed {
      class_type cls;
      score_type conf;
   } rank_type;

   function automatic score_type clamp_score(input score_type s);
      clamp_score = (s > SCORE_MAX) ? SCORE_MAX : s;
   endfunction

endpackage

[rtl/ksc_lane.sv]
// Keyword score confirmation lane: clamps one class score and decides whether
// it is the top score of the window (ties go to the lower class index).
`timescale 1ns / 1ps

module ksc_lane #(
   parameter int unsigned LANE = 0
) (
   input  ksc_pkg::score_type [ksc_pkg::CLASS_COUNT-1:0] scores,
   output ksc_pkg::score_type                            clamped,
   output logic                                          is_top
);
   import ksc_pkg::*;

   score_type own;

   assign own     = clamp_score(scores[LANE]);
   assign clamped = own;

   always_comb begin
      score_type other;
      is_top = 1'b1;
      for (int j = 0; j < int'(CLASS_COUNT); j++) begin
         other = clamp_score(scores[j]);
         if (j < int'(LANE)) begin
            if (!(own > other)) is_top = 1'b0;
         end else if (j > int'(LANE)) begin
            if (own < other) is_top = 1'b0;
         end
      end
   end

endmodule

[rtl/ksc_rank.sv]
// Keyword score confirmation merge stage: combines lane flags into the top
// class, its lead over the runner-up, and applies the on/off margin check.
`timescale 1ns / 1ps

module ksc_rank (
   input  ksc_pkg::score_type [ksc_pkg::CLASS_COUNT-1:0] clamped,
   input  logic [ksc_pkg::CLASS_COUNT-1:0]               is_top,
   input  logic [9:0]                                    min_margin,
   output ksc_pkg::rank_type                             rank
);
   import ksc_pkg::*;

   score_type best;
   score_type second;
   class_type best_idx;
   score_type margin;

   always_comb begin
      best     = '0;
      second   = '0;
      best_idx = CLS_NOISE;
      for (int i = 0; i < int'(CLASS_COUNT); i++) begin
         if (is_top[i]) begin
            best     = clamped[i];
            best_idx = CLASS_W'(i);
         end else if (clamped[i] > second) begin
            second = clamped[i];
         end
      end
   end

   assign margin = best - second;

   always_comb begin
      rank.cls  = best_idx;
      rank.conf = best;
      if ((best_idx == CLS_ON || best_idx == CLS_OFF) && margin < min_margin) begin
         rank.cls  = CLS_NOISE;
         rank.conf = SCORE_MAX - margin;
      end
   end

endmodule

[rtl/ksc_confirm.sv]
// Keyword score confirmation state: cooldown, anti-flip locks, candidate run,
// warmup and event counting. Updates once per item; result is combinational.
`timescale 1ns / 1ps

module ksc_confirm (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ksc_pkg::rank_type rank,
   input  ksc_pkg::cfg_type  cfg,
   output ksc_pkg::rsp_type  result
);
   import ksc_pkg::*;

   logic [COUNT_W-1:0] window_count_ff, window_count_in;
   logic [COUNT_W-1:0] event_count_ff, event_count_in;
   class_type          cand_class_ff, cand_class_in;
   logic [7:0]         cand_run_ff, cand_run_in;
   logic [7:0]         cooldown_ff, cooldown_in;
   logic [7:0]         on_lock_ff, on_lock_in;
   logic [7:0]         off_lock_ff, off_lock_in;
   logic               confirmed;

   always_comb begin
      logic       onoff;
      logic       locked;
      score_type  threshold;
      logic [7:0] needed;
      logic [7:0] cool_dec;
      logic [7:0] run_new;

      onoff    = (rank.cls == CLS_ON) || (rank.cls == CLS_OFF);
      cool_dec = (cooldown_ff != 8'd0) ? cooldown_ff - 8'd1 : 8'd0;

      window_count_in = window_count_ff + 32'd1;
      event_count_in  = event_count_ff;
      cooldown_in     = cool_dec;
      on_lock_in      = (on_lock_ff != 8'd0) ? on_lock_ff - 8'd1 : 8'd0;
      off_lock_in     = (off_lock_ff != 8'd0) ? off_lock_ff - 8'd1 : 8'd0;
      cand_class_in   = CLS_NOISE;
      cand_run_in     = 8'd0;
      confirmed       = 1'b0;

      locked    = (rank.cls == CLS_OFF && on_lock_in != 8'd0) ||
                  (rank.cls == CLS_ON && off_lock_in != 8'd0);
      threshold = onoff ? cfg.threshold_on_off : cfg.threshold_other;
      needed    = onoff ? cfg.confirm_on_off : cfg.confirm_other;

      if (rank.cls == cand_class_ff) begin
         run_new = (cand_run_ff < RUN_MAX) ? cand_run_ff + 8'd1 : cand_run_ff;
      end else begin
         run_new = 8'd1;
      end

      if (!locked && rank.cls != CLS_NOISE && rank.conf > threshold) begin
         cand_class_in = rank.cls;
         cand_run_in   = run_new;
         if (!(window_count_in < {24'd0, cfg.warmup_windows}) && !(run_new < needed) &&
             cool_dec == 8'd0) begin
            confirmed      = 1'b1;
            event_count_in = event_count_ff + 32'd1;
            cooldown_in    = cfg.cooldown_windows;
            cand_run_in    = 8'd0;
            if (rank.cls == CLS_ON) begin
               on_lock_in = cfg.anti_flip_windows;
            end else if (rank.cls == CLS_OFF) begin
               off_lock_in = cfg.anti_flip_windows;
            end
         end
      end
   end

   assign result.top_class          = rank.cls;
   assign result.top_confidence     = rank.conf;
   assign result.window_number      = window_count_in;
   assign result.prior_event_number = event_count_ff;
   assign result.confirmed          = confirmed;
   assign result.event_number       = event_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
         event_count_ff  <= '0;
         cand_class_ff   <= CLS_NOISE;
         cand_run_ff     <= '0;
         cooldown_ff     <= '0;
         on_lock_ff      <= '0;
         off_lock_ff     <= '0;
      end else if (advance) begin
         window_count_ff <= window_count_in;
         event_count_ff  <= event_count_in;
         cand_class_ff   <= cand_class_in;
         cand_run_ff     <= cand_run_in;
         cooldown_ff     <= cooldown_in;
         on_lock_ff      <= on_lock_in;
         off_lock_ff     <= off_lock_in;
      end
   end

endmodule

[rtl/keyword_score_confirmation.sv]
// Keyword score confirmation top level: register file, score lanes, merge
// stage, confirmation state and output register. Uses ksc_pkg.
`timescale 1ns / 1ps

// Takes one item of five permille class scores per clock while req_ready is
// high and returns one result per item, in order. An accepted item is held in
// the stage-one register, then passes the confirmation update into the output
// register (two stages: five parallel lanes plus a ranking merge, then the
// confirmation state update feeding the output register). Throughput is one
// item per cycle unless the result side stalls; stalls back up through both
// stages. Registers are written through the csr_ port and must only change
// while no item is in flight.
module keyword_score_confirmation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ksc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ksc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [ksc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ksc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ksc_pkg::*;

   cfg_type cfg_ff;

   score_type [CLASS_COUNT-1:0] scores;
   score_type [CLASS_COUNT-1:0] clamped;
   logic [CLASS_COUNT-1:0]      is_top;
   rank_type                    rank;

   logic     s1_valid_ff;
   rank_type s1_data_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   rsp_type  result;

   logic out_open;
   logic s1_open;
   logic advance;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD_ON_OFF:  cfg_ff.threshold_on_off  <= csr_wdata;
            REG_THRESHOLD_OTHER:   cfg_ff.threshold_other   <= csr_wdata;
            REG_CONFIRM_ON_OFF:    cfg_ff.confirm_on_off    <= csr_wdata[7:0];
            REG_CONFIRM_OTHER:     cfg_ff.confirm_other     <= csr_wdata[7:0];
            REG_COOLDOWN_WINDOWS:  cfg_ff.cooldown_windows  <= csr_wdata[7:0];
            REG_ANTI_FLIP_WINDOWS: cfg_ff.anti_flip_windows <= csr_wdata[7:0];
            REG_MIN_MARGIN:        cfg_ff.min_margin        <= csr_wdata;
            REG_WARMUP_WINDOWS:    cfg_ff.warmup_windows    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign scores[CLS_NOISE]   = req_data.score_noise;
   assign scores[CLS_OFF]     = req_data.score_off;
   assign scores[CLS_ON]      = req_data.score_on;
   assign scores[CLS_TIME]    = req_data.score_time;
   assign scores[CLS_WEATHER] = req_data.score_weather;

   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_lane
      ksc_lane #(
         .LANE (g)
      ) u_lane (
         .scores  (scores),
         .clamped (clamped[g]),
         .is_top  (is_top[g])
      );
   end

   ksc_rank u_rank (
      .clamped    (clamped),
      .is_top     (is_top),
      .min_margin (cfg_ff.min_margin),
      .rank       (rank)
   );

   // handshake: each stage moves when the next one is empty or draining
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s1_open   = !s1_valid_ff || out_open;
   assign advance   = s1_valid_ff && out_open;
   assign req_ready = s1_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open && req_valid) begin
         s1_data_ff <= rank;
      end
   end

   ksc_confirm u_confirm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rank    (s1_data_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
